>>> rtl/gdo_pkg.sv
`default_nettype none

package gdo_pkg;

	localparam int unsigned MAX_YEAR   = 9999;
	localparam int unsigned MAX_OFFSET = 65535;

	localparam int unsigned DAY_W  = 5;
	localparam int unsigned MON_W  = 4;
	localparam int unsigned YEAR_W = 14;
	localparam int unsigned OFS_W  = 17;
	localparam int unsigned REM_W  = 16;
	localparam int unsigned MOD_W  = 9;

	// y / 400 as (y * DIV400_MUL) >> DIV400_SHIFT, exact over the whole year field
	localparam int unsigned DIV400_MUL   = 10486;
	localparam int unsigned DIV400_SHIFT = 22;
	localparam int unsigned MUL_W        = 14;
	localparam int unsigned PROD_W       = YEAR_W + MUL_W;
	localparam int unsigned QUO_W        = PROD_W - DIV400_SHIFT;

	localparam logic [MOD_W-1:0]  MOD_LAST  = MOD_W'(399);
	localparam logic [MON_W-1:0]  MON_JAN   = MON_W'(1);
	localparam logic [MON_W-1:0]  MON_FEB   = MON_W'(2);
	localparam logic [MON_W-1:0]  MON_DEC   = MON_W'(12);
	localparam logic [YEAR_W-1:0] YEAR_MAX  = YEAR_W'(MAX_YEAR);
	localparam logic [REM_W-1:0]  OFS_CLAMP = REM_W'(MAX_OFFSET);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_DATE = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MOD,
		S_CHECK,
		S_STEP,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
		logic [MOD_W-1:0]  mod400;
		logic [REM_W-1:0]  rem;
	} walk_t;

	typedef struct packed {
		walk_t walk;
		logic  done;
		logic  range_err;
	} step_res_t;

	// leap year from the year taken modulo 400
	function automatic logic is_leap(input logic [MOD_W-1:0] mod400);
		logic century;
		century = (mod400 == MOD_W'(100)) || (mod400 == MOD_W'(200)) ||
			(mod400 == MOD_W'(300));
		return (mod400[1:0] == 2'b00) && !century;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		len = DAY_W'(31);
		case (m)
			4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
			4'd2:                    len = leap ? DAY_W'(29) : DAY_W'(28);
			default:                 len = DAY_W'(31);
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

>>> rtl/gdo_step.sv
`default_nettype none

// One month of the walk: either finish inside the current month or move
// to the neighbouring month boundary and charge the days crossed.
module gdo_step (
	input  wire gdo_pkg::walk_t     cur,
	input  wire logic               back,
	output gdo_pkg::step_res_t      res
);

	logic                         leap;
	logic [gdo_pkg::DAY_W-1:0]    mlen;
	logic [gdo_pkg::DAY_W-1:0]    left;
	logic [gdo_pkg::MON_W-1:0]    prev_m;
	logic [gdo_pkg::DAY_W-1:0]    prev_len;
	logic [gdo_pkg::YEAR_W:0]     year_up;
	logic [gdo_pkg::REM_W-1:0]    day_ext;
	logic [gdo_pkg::REM_W-1:0]    left_ext;

	assign leap     = gdo_pkg::is_leap(cur.mod400);
	assign mlen     = gdo_pkg::month_len(cur.month, leap);
	assign left     = mlen - cur.day;
	assign prev_m   = (cur.month == gdo_pkg::MON_JAN) ? gdo_pkg::MON_DEC
		: cur.month - gdo_pkg::MON_W'(1);
	// going back into February stays in the same year, so the current leap flag holds
	assign prev_len = gdo_pkg::month_len(prev_m, leap);
	assign year_up  = {1'b0, cur.year} + (gdo_pkg::YEAR_W+1)'(1);
	assign day_ext  = gdo_pkg::REM_W'(cur.day);
	assign left_ext = gdo_pkg::REM_W'(left);

	always_comb begin
		res           = '0;
		res.walk      = cur;
		res.done      = 1'b0;
		res.range_err = 1'b0;
		if (!back) begin
			if (cur.rem <= left_ext) begin
				res.walk.day = cur.day + gdo_pkg::DAY_W'(cur.rem);
				res.walk.rem = '0;
				res.done     = 1'b1;
			end else begin
				res.walk.rem = cur.rem - left_ext - gdo_pkg::REM_W'(1);
				res.walk.day = gdo_pkg::DAY_W'(1);
				if (cur.month == gdo_pkg::MON_DEC) begin
					res.walk.month  = gdo_pkg::MON_JAN;
					res.walk.year   = year_up[gdo_pkg::YEAR_W-1:0];
					res.walk.mod400 = (cur.mod400 == gdo_pkg::MOD_LAST) ? '0
						: cur.mod400 + gdo_pkg::MOD_W'(1);
					if (year_up > (gdo_pkg::YEAR_W+1)'(gdo_pkg::MAX_YEAR)) begin
						res.range_err = 1'b1;
						res.done      = 1'b1;
					end
				end else begin
					res.walk.month = cur.month + gdo_pkg::MON_W'(1);
				end
			end
		end else begin
			if (cur.rem < day_ext) begin
				res.walk.day = cur.day - gdo_pkg::DAY_W'(cur.rem);
				res.walk.rem = '0;
				res.done     = 1'b1;
			end else begin
				res.walk.rem   = cur.rem - day_ext;
				res.walk.month = prev_m;
				res.walk.day   = prev_len;
				if (cur.month == gdo_pkg::MON_JAN) begin
					res.walk.year   = cur.year - gdo_pkg::YEAR_W'(1);
					res.walk.mod400 = (cur.mod400 == '0) ? gdo_pkg::MOD_LAST
						: cur.mod400 - gdo_pkg::MOD_W'(1);
					if (cur.year == gdo_pkg::YEAR_W'(1)) begin
						res.range_err = 1'b1;
						res.done      = 1'b1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/gregorian_date_offset_unit.sv
`default_nettype none

// After the input beat is taken the sequencer passes through S_DIV, S_MOD and S_CHECK;
// a zero offset or a bad date then goes straight to S_OUT, while a nonzero offset walks
// month by month in S_STEP until done. The next beat is taken only once the result beat
// has gone, so result stalls hold off the next item.
// Reset (arst_n low) clears the sequencer to idle at once.
module gregorian_date_offset_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // day_in[4:0], month_in[8:5], year_in[22:9],
	                                        // offset_days[39:23]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // day_out[4:0], month_out[8:5], year_out[22:9]
	output logic [1:0]       m_axis_tuser   // status[1:0]
);

	gdo_pkg::state_t                 state_q, state_nx;
	gdo_pkg::walk_t                  walk_q;
	logic                            back_q;
	gdo_pkg::status_t                st_q;
	logic [gdo_pkg::PROD_W-1:0]      prod_q;
	gdo_pkg::step_res_t              step;

	logic [gdo_pkg::OFS_W-1:0]       ofs_raw;
	logic [gdo_pkg::OFS_W-1:0]       ofs_mag;
	logic [gdo_pkg::REM_W-1:0]       ofs_clamped;
	logic [gdo_pkg::QUO_W-1:0]       quo;
	logic [gdo_pkg::YEAR_W-1:0]      quo_x400;
	logic                            date_bad;
	logic [gdo_pkg::DAY_W-1:0]       in_len;

	assign ofs_raw     = s_axis_tdata[39:23];
	assign ofs_mag     = ofs_raw[gdo_pkg::OFS_W-1] ? (~ofs_raw + gdo_pkg::OFS_W'(1)) : ofs_raw;
	assign ofs_clamped = (ofs_mag > gdo_pkg::OFS_W'(gdo_pkg::MAX_OFFSET)) ? gdo_pkg::OFS_CLAMP
		: ofs_mag[gdo_pkg::REM_W-1:0];

	assign quo      = prod_q[gdo_pkg::PROD_W-1:gdo_pkg::DIV400_SHIFT];
	assign quo_x400 = gdo_pkg::YEAR_W'(quo * gdo_pkg::YEAR_W'(400));

	assign in_len   = gdo_pkg::month_len(walk_q.month, gdo_pkg::is_leap(walk_q.mod400));
	assign date_bad = (walk_q.month < gdo_pkg::MON_JAN) || (walk_q.month > gdo_pkg::MON_DEC) ||
		(walk_q.year == '0) || (walk_q.year > gdo_pkg::YEAR_MAX) ||
		(walk_q.day == '0) || (walk_q.day > in_len);

	gdo_step u_step (
		.cur  (walk_q),
		.back (back_q),
		.res  (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdo_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx      = state_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		unique case (state_q)
			gdo_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_nx = gdo_pkg::S_DIV;
			end
			gdo_pkg::S_DIV:   state_nx = gdo_pkg::S_MOD;
			gdo_pkg::S_MOD:   state_nx = gdo_pkg::S_CHECK;
			gdo_pkg::S_CHECK: begin
				if (date_bad || walk_q.rem == '0) state_nx = gdo_pkg::S_OUT;
				else                              state_nx = gdo_pkg::S_STEP;
			end
			gdo_pkg::S_STEP: begin
				if (step.done) state_nx = gdo_pkg::S_OUT;
			end
			gdo_pkg::S_OUT: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) state_nx = gdo_pkg::S_IDLE;
			end
			default: state_nx = gdo_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			gdo_pkg::S_IDLE: begin
				if (s_axis_tvalid) begin
					walk_q.day    <= s_axis_tdata[4:0];
					walk_q.month  <= s_axis_tdata[8:5];
					walk_q.year   <= s_axis_tdata[22:9];
					walk_q.mod400 <= '0;
					walk_q.rem    <= ofs_clamped;
					back_q        <= ofs_raw[gdo_pkg::OFS_W-1];
					st_q          <= gdo_pkg::ST_OK;
				end
			end
			gdo_pkg::S_DIV: begin
				prod_q <= gdo_pkg::PROD_W'(walk_q.year) *
					gdo_pkg::PROD_W'(gdo_pkg::DIV400_MUL);
			end
			gdo_pkg::S_MOD: begin
				walk_q.mod400 <= gdo_pkg::MOD_W'(walk_q.year - quo_x400);
			end
			gdo_pkg::S_CHECK: begin
				if (date_bad) st_q <= gdo_pkg::ST_BAD_DATE;
			end
			gdo_pkg::S_STEP: begin
				walk_q <= step.walk;
				if (step.range_err) st_q <= gdo_pkg::ST_RANGE;
			end
			gdo_pkg::S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// blank the date on any error
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tuser = st_q;
		if (st_q == gdo_pkg::ST_OK) begin
			m_axis_tdata[4:0]  = walk_q.day;
			m_axis_tdata[8:5]  = walk_q.month;
			m_axis_tdata[22:9] = walk_q.year;
		end
	end

endmodule

`default_nettype wire

>>> tb/tb_gregorian_date_offset_unit.sv
`default_nettype none

module tb_gregorian_date_offset_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3_000_000;

	typedef struct packed {
		logic [4:0]       day;
		logic [3:0]       month;
		logic [13:0]      year;
		gdo_pkg::status_t status;
	} date_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // day_in[4:0], month_in[8:5], year_in[22:9], offset_days[39:23]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // day_out[4:0], month_out[8:5], year_out[22:9]
	logic [1:0]  m_axis_tuser;   // status[1:0]

	date_result_t expected_dates[$];
	int           mismatch_count;
	int           cycle_count;
	bit           idle_on;

	gregorian_date_offset_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit leap_year_check(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		int unsigned len;
		case (m)
			4, 6, 9, 11: len = 30;
			2:           len = leap_year_check(y) ? 29 : 28;
			default:     len = 31;
		endcase
		return len;
	endfunction

	function automatic date_result_t predict_offset_date(input logic [4:0] d_in,
		input logic [3:0] m_in, input logic [13:0] y_in, input logic [16:0] ofs);
		date_result_t res;
		int unsigned  d, m, y, left, remaining;
		bit           back;
		d = d_in;
		m = m_in;
		y = y_in;
		back = ofs[16];
		remaining = back ? (32'h20000 - 32'(ofs)) : 32'(ofs);
		if (remaining > gdo_pkg::MAX_OFFSET)
			remaining = gdo_pkg::MAX_OFFSET;
		res.status = gdo_pkg::ST_OK;
		if (m < 1 || m > 12 || y < 1 || y > gdo_pkg::MAX_YEAR || d < 1 ||
			d > days_in_month(m, y)) begin
			res.status = gdo_pkg::ST_BAD_DATE;
		end else if (!back) begin
			while (remaining > 0 && res.status == gdo_pkg::ST_OK) begin
				left = days_in_month(m, y) - d;
				if (remaining <= left) begin
					d += remaining;
					remaining = 0;
				end else begin
					remaining -= left + 1;
					d = 1;
					if (m == 12) begin
						m = 1;
						y++;
						if (y > gdo_pkg::MAX_YEAR)
							res.status = gdo_pkg::ST_RANGE;
					end else begin
						m++;
					end
				end
			end
		end else begin
			while (remaining > 0 && res.status == gdo_pkg::ST_OK) begin
				if (remaining < d) begin
					d -= remaining;
					remaining = 0;
				end else begin
					remaining -= d;
					if (m == 1) begin
						m = 12;
						y--;
						if (y == 0)
							res.status = gdo_pkg::ST_RANGE;
					end else begin
						m--;
					end
					d = days_in_month(m, y);
				end
			end
		end
		if (res.status == gdo_pkg::ST_OK) begin
			res.day = 5'(d);
			res.month = 4'(m);
			res.year = 14'(y);
		end else begin
			res.day = '0;
			res.month = '0;
			res.year = '0;
		end
		return res;
	endfunction

	// one beat in; the expectation is queued at the edge that accepts it
	task automatic send_date(input int unsigned d, input int unsigned m, input int unsigned y,
		input int offset);
		int unsigned gap;
		logic [16:0] ofs;
		gap = 0;
		ofs = 17'(offset);
		if (idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 7);
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {ofs, 14'(y), 4'(m), 5'(d)};
		do @(posedge clk); while (!s_axis_tready);
		expected_dates.push_back(predict_offset_date(5'(d), 4'(m), 14'(y), ofs));
	endtask

	task automatic pick_valid_date(input int unsigned y_lo, input int unsigned y_hi,
		output int unsigned d, output int unsigned m, output int unsigned y);
		y = $urandom_range(y_lo, y_hi);
		m = $urandom_range(1, 12);
		d = $urandom_range(1, days_in_month(m, y));
	endtask

	task automatic test_day_steps();
		send_date(15, 6, 2020, 0);
		send_date(31, 12, 1999, 1);
		send_date(1, 3, 2000, -1);
		send_date(1, 3, 1900, -1);
		send_date(28, 2, 2024, 1);
		send_date(31, 1, 2023, 1);
		send_date(1, 1, 2001, -1);
	endtask

	task automatic test_bad_dates();
		send_date(0, 5, 2000, 10);
		send_date(12, 0, 2000, 5);
		send_date(1, 13, 2000, 1);
		send_date(5, 15, 2000, 0);
		send_date(1, 1, 0, 3);
		send_date(1, 1, gdo_pkg::MAX_YEAR + 1, 0);
		send_date(31, 4, 2021, 0);
		send_date(29, 2, 1900, 1);
		send_date(30, 2, 2000, -1);
		send_date(31, 1, 16383, 65535);
	endtask

	task automatic test_range_and_clamp();
		send_date(31, 12, gdo_pkg::MAX_YEAR, 1);
		send_date(1, 1, 1, -1);
		send_date(31, 12, gdo_pkg::MAX_YEAR, 0);
		send_date(1, 1, 1, 65535);
		send_date(31, 12, gdo_pkg::MAX_YEAR, -65535);
		// field value -65536 is clamped to one day less
		send_date(15, 7, 5000, -65536);
		send_date(1, 1, 1, -65536);
		send_date(20, 8, 3000, 65535);
	endtask

	task automatic test_random_walks(input int count, input bit with_idle);
		int unsigned d, m, y, mag, pick;
		for (int i = 0; i < count; i++) begin
			// leave quiet stretches between the busy ones
			idle_on = with_idle && ((i % 60) < 45);
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				send_date($urandom_range(0, 31), $urandom_range(0, 15),
					$urandom_range(0, 16383), $urandom_range(0, 131071));
				continue;
			end
			if (pick < 18) begin
				if ($urandom_range(0, 1))
					pick_valid_date(1, 3, d, m, y);
				else
					pick_valid_date(gdo_pkg::MAX_YEAR - 2, gdo_pkg::MAX_YEAR, d, m, y);
				mag = $urandom_range(0, 1500);
			end else if (pick < 22) begin
				pick_valid_date(1, gdo_pkg::MAX_YEAR, d, m, y);
				mag = $urandom_range(30000, 65535);
			end else begin
				pick_valid_date(1, gdo_pkg::MAX_YEAR, d, m, y);
				mag = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 62) : $urandom_range(0, 1200);
			end
			send_date(d, m, y, $urandom_range(0, 1) ? -int'(mag) : int'(mag));
		end
	endtask

	// result side stalls in bursts
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		date_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_dates.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat: day %0d month %0d year %0d status %0d",
						m_axis_tdata[4:0], m_axis_tdata[8:5], m_axis_tdata[22:9], m_axis_tuser);
			end else begin
				want = expected_dates.pop_front();
				if (m_axis_tdata[4:0] !== want.day || m_axis_tdata[8:5] !== want.month ||
					m_axis_tdata[22:9] !== want.year || m_axis_tuser !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %0d/%0d/%0d status %0d, got %0d/%0d/%0d status %0d",
							want.day, want.month, want.year, want.status,
							m_axis_tdata[4:0], m_axis_tdata[8:5], m_axis_tdata[22:9], m_axis_tuser);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		mismatch_count = 0;
		cycle_count = 0;
		idle_on = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		idle_on = 1'b1;
		test_day_steps();
		test_bad_dates();
		test_range_and_clamp();
		test_random_walks(215, 1'b1);
		idle_on = 1'b0;
		test_random_walks(30, 1'b0);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_dates.size() != 0) @(posedge clk);
		repeat (32) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
rtl/gdo_pkg.sv
rtl/gdo_step.sv
rtl/gregorian_date_offset_unit.sv
tb/tb_gregorian_date_offset_unit.sv
